// ===== rtl/core/tcw_pkg.sv =====
package tcw_pkg;

    // Command codes carried by the input word.
    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_MOVE  = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    // Port widths of the fields.
    localparam int CMD_W        = 2;
    localparam int CHAR_W       = 8;
    localparam int MOVE_X_W     = 8;
    localparam int MOVE_Y_W     = 6;
    localparam int CELL_ADDR_W  = 11;
    localparam int CURSOR_POS_W = 11;
    localparam int CURSOR_ROW_W = 5;
    localparam int CURSOR_COL_W = 7;
    localparam int CELL_W       = 16;
    localparam int COLOR_W      = 8;

    // Character and cell codes.
    localparam logic [CHAR_W-1:0]  CHAR_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0]  CHAR_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0]  CHAR_SPACE     = 8'h20;
    localparam logic [CELL_W-1:0]  CELL_RESET     = 16'h0720;
    localparam logic [CELL_W-1:0]  CELL_BLANK     = 16'h0F20;
    localparam logic [COLOR_W-1:0] COLOR_RESET    = 8'h07;

endpackage

// ===== rtl/core/text_console_writer_top.sv =====
// Text console writer: a screen store of ROWS x COLUMNS cells, each a 16-bit word with
// the attribute in the high byte and the character in the low byte, plus a cursor.
// Input channel (i_in_valid / o_in_stall): one command word per item, either put a
// character, clear the screen, move the cursor or read one cell. Output channel
// (o_out_valid / i_out_stall): exactly one result word per command, holding the
// cursor after the command and, for a read, the stored cell word.
// Configuration channel (i_cfg_valid / o_cfg_ready): writes the text color used for
// written characters and backspace blanks. It is always ready.
// Sequence: an ordinary put, a move or a read accepts the word and issues the memory
// access, then loads the result register once the output can take it. A newline on the
// last row, or a put in the last column of the last row, scrolls, which walks the
// store once through the memory read and write ports before the result is loaded.
// A clear fills the store with blanks, one cell written per cycle.
// Reset: the cursor and color return to their reset values and the block runs a
// clearing pass that fills every cell with the grey blank; input stays stalled
// meanwhile, configuration writes are taken.
// When the receiver stalls, the result waits in the output register and the block
// holds in its response state until the register can be reloaded.
module text_console_writer_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [tcw_pkg::COLOR_W-1:0]       i_cfg_data,
    output logic                              o_cfg_ready,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [tcw_pkg::CMD_W-1:0]         i_cmd,
    input  logic [tcw_pkg::CHAR_W-1:0]        i_char_code,
    input  logic signed [tcw_pkg::MOVE_X_W-1:0] i_move_x,
    input  logic signed [tcw_pkg::MOVE_Y_W-1:0] i_move_y,
    input  logic [tcw_pkg::CELL_ADDR_W-1:0]   i_cell_addr,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [tcw_pkg::CURSOR_POS_W-1:0]  o_cursor_pos,
    output logic [tcw_pkg::CURSOR_ROW_W-1:0]  o_cursor_row,
    output logic [tcw_pkg::CURSOR_COL_W-1:0]  o_cursor_col,
    output logic [tcw_pkg::CELL_W-1:0]        o_cell_word
);
    import tcw_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int CA_W   = (ADDR_W > CELL_ADDR_W) ? ADDR_W : CELL_ADDR_W;
    localparam int SX_W   = ((COL_W > MOVE_X_W) ? COL_W : MOVE_X_W) + 2;
    localparam int SY_W   = ((ROW_W > MOVE_Y_W) ? ROW_W : MOVE_Y_W) + 2;
    localparam int KEEP   = (ROWS - 1) * COLUMNS;

    localparam logic signed [SX_W-1:0] SX_MAX = SX_W'(COLUMNS - 1);
    localparam logic signed [SY_W-1:0] SY_MAX = SY_W'(ROWS - 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCROLL,
        ST_FILL,
        ST_RESP
    } t_state;

    // Linear cell index of a row and column.
    function automatic logic [ADDR_W-1:0] f_lin(input logic [ROW_W-1:0] row,
                                                input logic [COL_W-1:0] col);
        f_lin = ADDR_W'(32'(row) * COLUMNS + 32'(col));
    endfunction

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [ROW_W-1:0]      r_row, n_row;
    logic [COL_W-1:0]      r_col, n_col;
    logic [COL_W-1:0]      r_prev, n_prev;
    logic [COLOR_W-1:0]    r_color, n_color;
    logic                  r_is_read, n_is_read;
    logic                  r_out_vld, n_out_vld;
    logic [CURSOR_POS_W-1:0] r_pos, n_pos;
    logic [CURSOR_ROW_W-1:0] r_orow, n_orow;
    logic [CURSOR_COL_W-1:0] r_ocol, n_ocol;
    logic [CELL_W-1:0]     r_word, n_word;

    logic [CELL_W-1:0]     mem [CELLS];
    logic [CELL_W-1:0]     r_rdata;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [CELL_W-1:0]     wr_data;

    logic                  accept;
    logic                  out_free;
    logic [COL_W:0]        col_inc;
    logic [ROW_W:0]        row_inc;
    logic [COL_W-1:0]      bs_col;
    logic [ROW_W-1:0]      bs_row;
    logic                  last_row;
    logic signed [SX_W-1:0] sx;
    logic signed [SY_W-1:0] sy;
    logic [CA_W-1:0]       ca_ext;
    logic                  ca_ok;
    logic [CNT_W-1:0]      scr_src;
    logic [CNT_W-1:0]      scr_dst;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_vld || !i_out_stall;

    assign col_inc  = (COL_W + 1)'(r_col) + 1'b1;
    assign row_inc  = (ROW_W + 1)'(r_row) + 1'b1;
    assign last_row = !(row_inc < (ROW_W + 1)'(ROWS));
    assign bs_col   = (r_col == '0) ? ((r_prev > COL_LAST) ? COL_LAST : r_prev)
                                    : r_col - 1'b1;
    assign bs_row   = (r_col == '0) ? r_row - 1'b1 : r_row;
    assign sx       = $signed(SX_W'(r_col)) + SX_W'(i_move_x);
    assign sy       = $signed(SY_W'(r_row)) + SY_W'(i_move_y);
    assign ca_ext   = CA_W'(i_cell_addr);
    assign ca_ok    = ca_ext < CA_W'(CELLS);
    assign scr_src  = r_cnt + CNT_W'(COLUMNS);
    assign scr_dst  = r_cnt - 1'b1;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_row     = r_row;
        n_col     = r_col;
        n_prev    = r_prev;
        n_color   = r_color;
        n_is_read = r_is_read;
        n_out_vld = r_out_vld && i_out_stall;
        n_pos     = r_pos;
        n_orow    = r_orow;
        n_ocol    = r_ocol;
        n_word    = r_word;
        rd_en     = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_addr   = '0;
        wr_data   = '0;

        if (i_cfg_valid && o_cfg_ready) begin
            n_color = i_cfg_data;
        end

        case (r_state)
            ST_INIT, ST_FILL: begin
                wr_en   = 1'b1;
                wr_addr = r_cnt[ADDR_W-1:0];
                wr_data = (r_state == ST_INIT) ? CELL_RESET : CELL_BLANK;
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(CELLS - 1)) begin
                    n_cnt   = '0;
                    n_state = (r_state == ST_INIT) ? ST_IDLE : ST_RESP;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_is_read = 1'b0;
                    n_state   = ST_RESP;
                    n_cnt     = '0;
                    case (t_cmd'(i_cmd))
                        CMD_PUT: begin
                            if (i_char_code == CHAR_NEWLINE) begin
                                n_prev = r_col;
                                n_col  = '0;
                                if (last_row) begin
                                    n_state = ST_SCROLL;
                                end else begin
                                    n_row = row_inc[ROW_W-1:0];
                                end
                            end else if (i_char_code == CHAR_BACKSPACE) begin
                                // Backspace at the origin leaves everything as it is.
                                if (r_col != '0 || r_row != '0) begin
                                    n_col   = bs_col;
                                    n_row   = bs_row;
                                    wr_en   = 1'b1;
                                    wr_addr = f_lin(bs_row, bs_col);
                                    wr_data = {r_color, CHAR_SPACE};
                                end
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = f_lin(r_row, r_col);
                                wr_data = {r_color, i_char_code};
                                if (col_inc < (COL_W + 1)'(COLUMNS)) begin
                                    n_col = col_inc[COL_W-1:0];
                                end else begin
                                    n_col  = '0;
                                    n_prev = COL_LAST;
                                    if (last_row) begin
                                        n_state = ST_SCROLL;
                                    end else begin
                                        n_row = row_inc[ROW_W-1:0];
                                    end
                                end
                            end
                        end
                        CMD_CLEAR: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_state = ST_FILL;
                        end
                        CMD_MOVE: begin
                            if (sx < 0) begin
                                n_col = '0;
                            end else if (sx > SX_MAX) begin
                                n_col = COL_LAST;
                            end else begin
                                n_col = sx[COL_W-1:0];
                            end
                            if (sy < 0) begin
                                n_row = '0;
                            end else if (sy > SY_MAX) begin
                                n_row = ROW_LAST;
                            end else begin
                                n_row = sy[ROW_W-1:0];
                            end
                        end
                        CMD_READ: begin
                            // An address past the screen reads as zero.
                            n_is_read = ca_ok;
                            rd_en     = ca_ok;
                            rd_addr   = ca_ext[ADDR_W-1:0];
                        end
                        default: begin
                            n_state = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SCROLL: begin
                // Read one row ahead, write the word read last cycle one row up.
                // The bottom row is filled with blanks as the sweep passes it.
                if (scr_src < CNT_W'(CELLS)) begin
                    rd_en   = 1'b1;
                    rd_addr = scr_src[ADDR_W-1:0];
                end
                if (r_cnt != '0) begin
                    wr_en   = 1'b1;
                    wr_addr = scr_dst[ADDR_W-1:0];
                    wr_data = (scr_dst < CNT_W'(KEEP)) ? r_rdata : CELL_BLANK;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(CELLS)) begin
                    n_cnt   = '0;
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_pos     = CURSOR_POS_W'(f_lin(r_row, r_col));
                    n_orow    = CURSOR_ROW_W'(r_row);
                    n_ocol    = CURSOR_COL_W'(r_col);
                    n_word    = r_is_read ? r_rdata : '0;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_cnt     <= '0;
            r_row     <= '0;
            r_col     <= '0;
            r_prev    <= '0;
            r_color   <= COLOR_RESET;
            r_is_read <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_row     <= n_row;
            r_col     <= n_col;
            r_prev    <= n_prev;
            r_color   <= n_color;
            r_is_read <= n_is_read;
            r_out_vld <= n_out_vld;
            r_pos     <= n_pos;
            r_orow    <= n_orow;
            r_ocol    <= n_ocol;
            r_word    <= n_word;
        end
    end

    // Screen store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_cursor_pos = r_pos;
    assign o_cursor_row = r_orow;
    assign o_cursor_col = r_ocol;
    assign o_cell_word  = r_word;

    // The cursor never leaves the screen.
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_col) < COLUMNS) && (32'(r_row) < ROWS))
        else $error("cursor outside the screen");

    // No result can be pending while the reset clearing pass runs.
    a_init_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INIT) |-> !o_out_valid)
        else $error("result valid during the clearing pass");

    // An accepted word always moves the block out of its idle state.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != ST_IDLE))
        else $error("block idle right after accepting a word");

    // The scroll sweep stops at the end of the store.
    a_scroll_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCROLL) |-> (32'(r_cnt) <= CELLS))
        else $error("scroll sweep ran past the store");

    // A result that is stalled is never overwritten.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESP && o_out_valid && i_out_stall) |=> (r_state == ST_RESP))
        else $error("response left while the output was stalled");

endmodule
